FILE: sv/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg - shared definitions for the single-wire humidity sensor reader
// Widths, register indexes, status codes and the decode result record.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int PULSE_PAIRS  = 41;
  localparam int DATA_BITS    = PULSE_PAIRS - 1;
  localparam int SUM_BITS     = 30;
  localparam int IDX_BITS     = $clog2(PULSE_PAIRS + 1);
  localparam int BITCNT_BITS  = $clog2(DATA_BITS);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_PREAMBLE_HIGH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_LOW     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_HIGH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT       = 2'd3;

  localparam logic [COUNT_BITS-1:0] PREAMBLE_HIGH_RST = 24'd500000;
  localparam logic [COUNT_BITS-1:0] START_LOW_RST     = 24'd20000;
  localparam logic [COUNT_BITS-1:0] RELEASE_HIGH_RST  = 24'd30;
  localparam logic [COUNT_BITS-1:0] TIMEOUT_RST       = 24'd3200000;

  // Read completion status codes.
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_RESPONSE   = 2'd1;
  localparam logic [1:0] ST_PULSE_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CHECKSUM      = 2'd3;

  typedef struct packed {
    logic        done;
    logic [1:0]  status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } dht_result_t;

endpackage

FILE: sv/dht22_single_wire_reader_unit.sv
// ----------------------------------------------------------------------------
// dht22_single_wire_reader_unit - single-wire temperature/humidity reader
// Generates the start sequence on the wire, times the sensor's pulse train
// tick by tick, and decodes the 40-bit frame into tenths of a unit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o   | mode_i, pin_level_i
//  out     | output    | out_valid_o / out_stall_i | drive_enable_o, drive_level_o,
//          |           |                          | done_res_o, status_o,
//          |           |                          | humidity_tenths_o,
//          |           |                          | temperature_tenths_o
//  cfg     | input     | cfg_we_i (no wait)       | cfg_index_i, cfg_wdata_i
//
// Every input transfer yields exactly one output transfer. A start item or a
// tick item has its result loaded into the output register in the cycle that
// accepts it. The tick that ends the last high pulse of a frame is accepted
// first; then the width chain drains through the serial bit slicer, the
// checksum and conversion are done, and the result is loaded.
// The input is stalled while the frame is decoded and while a result
// is stalled at the output. Reset is asynchronous and active low; it returns
// the sequencer to idle and loads the default timing registers.
//
// The 40 high-pulse widths live in a chain of cells. Each data high pulse
// shifts its width into the head of the chain, so after a full frame the
// first bit sits in the last cell and drains out first (MSB first).
// ----------------------------------------------------------------------------
module dht22_single_wire_reader_unit
  import dht_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input item channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic                    pin_level_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    drive_enable_o,
  output logic                    drive_level_o,
  output logic                    done_res_o,
  output logic [1:0]              status_o,
  output logic [15:0]             humidity_tenths_o,
  output logic signed [15:0]      temperature_tenths_o,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_START_LOW,
    PH_REL,
    PH_WAIT,
    PH_LOW,
    PH_HIGH,
    PH_DECODE
  } phase_e;

  // Timing registers.
  logic [COUNT_BITS-1:0] pre_q, start_q, rel_q, timeout_q;

  // Sequencer state.
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [IDX_BITS-1:0]   pidx_q, pidx_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;

  // Output register.
  logic        out_valid_q;
  logic        drv_en_q, drv_lvl_q, done_q;
  logic [1:0]  status_q;
  logic [15:0] hum_q, temp_q;

  logic                  in_acc;
  logic                  out_load;
  logic                  go_decode;
  logic                  store_width;
  logic                  r_done;
  logic [1:0]            r_status;
  logic [COUNT_BITS-1:0] tick_inc;
  logic [COUNT_BITS-1:0] drv_len;
  logic                  tmo;
  logic                  tmo_first;
  logic                  next_drv;

  logic                  chain_shift;
  logic                  dec_shift;
  logic [COUNT_BITS-1:0] cell_out [DATA_BITS];
  dht_result_t           dec_res;

  // Skips drive phases whose programmed length is zero.
  function automatic phase_e skip_empty(phase_e p, logic [COUNT_BITS-1:0] pre,
                                        logic [COUNT_BITS-1:0] stl,
                                        logic [COUNT_BITS-1:0] rel);
    phase_e ph;
    ph = p;
    if (ph == PH_PRE && pre == '0) ph = PH_START_LOW;
    if (ph == PH_START_LOW && stl == '0) ph = PH_REL;
    if (ph == PH_REL && rel == '0) ph = PH_WAIT;
    return ph;
  endfunction

  assign in_stall_o = (phase_q == PH_DECODE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Tick counters saturate at the top of their range.
  assign tick_inc  = (tick_q == COUNT_MAX) ? tick_q : tick_q + 1'b1;
  assign tmo       = tick_inc >= timeout_q;
  // A wait that begins on this sample has counted one tick.
  assign tmo_first = timeout_q <= COUNT_BITS'(1);

  always_comb begin
    case (phase_q)
      PH_PRE:       drv_len = pre_q;
      PH_START_LOW: drv_len = start_q;
      default:      drv_len = rel_q;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    pidx_d      = pidx_q;
    sum_d       = sum_q;
    r_done      = 1'b0;
    r_status    = ST_OK;
    go_decode   = 1'b0;
    store_width = 1'b0;

    if (in_acc) begin
      if (mode_i) begin
        // A start aborts any read in progress.
        phase_d = skip_empty(PH_PRE, pre_q, start_q, rel_q);
        tick_d  = '0;
        pidx_d  = '0;
        sum_d   = '0;
      end else begin
        case (phase_q)
          PH_PRE, PH_START_LOW, PH_REL: begin
            if (tick_inc >= drv_len) begin
              tick_d = '0;
              if (phase_q == PH_PRE) begin
                phase_d = skip_empty(PH_START_LOW, pre_q, start_q, rel_q);
              end else if (phase_q == PH_START_LOW) begin
                phase_d = skip_empty(PH_REL, pre_q, start_q, rel_q);
              end else begin
                phase_d = PH_WAIT;
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          PH_WAIT: begin
            if (pin_level_i) begin
              if (tmo) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_NO_RESPONSE;
              end else begin
                tick_d = tick_inc;
              end
            end else begin
              // The sensor answered: this sample opens the response low pulse.
              pidx_d = '0;
              sum_d  = '0;
              if (tmo_first) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_PULSE_TIMEOUT;
              end else begin
                phase_d = PH_LOW;
                tick_d  = COUNT_BITS'(1);
              end
            end
          end
          PH_LOW: begin
            if (!pin_level_i) begin
              if (tmo) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_PULSE_TIMEOUT;
              end else begin
                tick_d = tick_inc;
              end
            end else begin
              if (pidx_q != '0) begin
                sum_d = sum_q + SUM_BITS'(tick_q);
              end
              if (tmo_first) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_PULSE_TIMEOUT;
              end else begin
                phase_d = PH_HIGH;
                tick_d  = COUNT_BITS'(1);
              end
            end
          end
          PH_HIGH: begin
            if (pin_level_i) begin
              if (tmo) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_PULSE_TIMEOUT;
              end else begin
                tick_d = tick_inc;
              end
            end else begin
              // The response pair is not a data bit and is not stored.
              store_width = (pidx_q != '0);
              pidx_d      = pidx_q + 1'b1;
              if (pidx_q == IDX_BITS'(DATA_BITS)) begin
                phase_d   = PH_DECODE;
                go_decode = 1'b1;
              end else if (tmo_first) begin
                phase_d  = PH_IDLE;
                tick_d   = '0;
                r_done   = 1'b1;
                r_status = ST_PULSE_TIMEOUT;
              end else begin
                phase_d = PH_LOW;
                tick_d  = COUNT_BITS'(1);
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end else if (phase_q == PH_DECODE && dec_res.done) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
    end
  end

  assign next_drv = (phase_d == PH_PRE) || (phase_d == PH_START_LOW) ||
                    (phase_d == PH_REL);
  assign out_load = (in_acc && !go_decode) || (phase_q == PH_DECODE && dec_res.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q       <= PREAMBLE_HIGH_RST;
      start_q     <= START_LOW_RST;
      rel_q       <= RELEASE_HIGH_RST;
      timeout_q   <= TIMEOUT_RST;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      pidx_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PREAMBLE_HIGH: pre_q     <= cfg_wdata_i;
          REG_START_LOW:     start_q   <= cfg_wdata_i;
          REG_RELEASE_HIGH:  rel_q     <= cfg_wdata_i;
          REG_TIMEOUT:       timeout_q <= cfg_wdata_i;
          default:           ;
        endcase
      end
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pidx_q  <= pidx_d;
      sum_q   <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (phase_q == PH_DECODE) begin
        drv_en_q  <= 1'b0;
        drv_lvl_q <= 1'b0;
        done_q    <= dec_res.done;
        status_q  <= dec_res.status;
        hum_q     <= dec_res.humidity;
        temp_q    <= dec_res.temperature;
      end else begin
        drv_en_q  <= next_drv;
        drv_lvl_q <= next_drv && (phase_d != PH_START_LOW);
        done_q    <= r_done;
        status_q  <= r_status;
        hum_q     <= '0;
        temp_q    <= '0;
      end
    end
  end

  // High-pulse width chain.
  assign chain_shift = store_width || dec_shift;

  for (genvar i = 0; i < DATA_BITS; i++) begin : g_cell
    if (i == 0) begin : g_head
      dht_width_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (chain_shift),
        .width_i (tick_q),
        .width_o (cell_out[i])
      );
    end else begin : g_body
      dht_width_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (chain_shift),
        .width_i (cell_out[i-1]),
        .width_o (cell_out[i])
      );
    end
  end

  dht_bit_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (go_decode),
    .low_sum_i (sum_q),
    .width_i   (cell_out[DATA_BITS-1]),
    .shift_o   (dec_shift),
    .result_o  (dec_res)
  );

  assign out_valid_o          = out_valid_q;
  assign drive_enable_o       = drv_en_q;
  assign drive_level_o        = drv_lvl_q;
  assign done_res_o           = done_q;
  assign status_o             = status_q;
  assign humidity_tenths_o    = hum_q;
  assign temperature_tenths_o = temp_q;

`ifndef NO_ASSERTIONS
  // A decoded frame must never land on a result that is still waiting.
  a_dec_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DECODE && dec_res.done) |-> !out_valid_q)
    else $error("decode result would overwrite a pending result");

  // The chain only drains while the sequencer is decoding a frame.
  a_drain_in_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_shift |-> (phase_q == PH_DECODE))
    else $error("width chain drained outside of decode");

  // The pulse counter never runs past the last pulse pair.
  a_pidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LOW || phase_q == PH_HIGH) |-> (pidx_q <= IDX_BITS'(DATA_BITS)))
    else $error("pulse index out of range");

  // A finished read always leaves the wire released.
  a_done_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !drive_enable_o)
    else $error("read finished while the wire is driven");

  // Status and readings are zero on results that do not end a read.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |->
      (status_o == ST_OK && humidity_tenths_o == 16'd0))
    else $error("nonzero status on a result that does not end a read");
`endif

endmodule

FILE: sv/dht_width_cell.sv
// ----------------------------------------------------------------------------
// dht_width_cell - one stage of the high-pulse width chain
// Holds one measured width and passes it to the next stage on a shift.
// ----------------------------------------------------------------------------
module dht_width_cell
  import dht_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic [COUNT_BITS-1:0] width_i,
  output logic [COUNT_BITS-1:0] width_o
);

  logic [COUNT_BITS-1:0] width_q;
  logic [COUNT_BITS-1:0] width_d;

  assign width_d = shift_i ? width_i : width_q;

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
  end

  assign width_o = width_q;

endmodule

FILE: sv/dht_bit_decoder.sv
// ----------------------------------------------------------------------------
// dht_bit_decoder - serial bit slicer and frame checker
// Drains the width chain one entry per cycle, slices each width against the
// mean low width, then checks the sum byte and converts the readings.
// ----------------------------------------------------------------------------
module dht_bit_decoder
  import dht_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_BITS-1:0]   low_sum_i,
  input  logic [COUNT_BITS-1:0] width_i,
  output logic                  shift_o,
  output dht_result_t           result_o
);

  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_SHIFT,
    DEC_CHECK
  } dec_state_e;

  dec_state_e               state_q;
  logic [BITCNT_BITS-1:0]   cnt_q;
  logic [DATA_BITS-1:0]     bits_q;
  dht_result_t              res_q;

  logic [SUM_BITS-1:0] scaled;
  logic                bit_val;
  logic [7:0]          b0, b1, b2, b3, b4;
  logic [7:0]          sum8;
  logic [15:0]         mag;

  // A width w is a one when w >= floor(sum / 40), which is 40 * w + 40 > sum.
  assign scaled  = {1'b0, width_i, 5'b0} + {3'b0, width_i, 3'b0}
                 + SUM_BITS'(DATA_BITS);
  assign bit_val = scaled > low_sum_i;

  assign b0   = bits_q[39:32];
  assign b1   = bits_q[31:24];
  assign b2   = bits_q[23:16];
  assign b3   = bits_q[15:8];
  assign b4   = bits_q[7:0];
  assign sum8 = b0 + b1 + b2 + b3;
  assign mag  = {1'b0, b2[6:0], b3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DEC_IDLE;
      cnt_q   <= '0;
      bits_q  <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        DEC_IDLE: begin
          res_q.done <= 1'b0;
          cnt_q      <= '0;
          if (start_i) begin
            state_q <= DEC_SHIFT;
          end
        end
        DEC_SHIFT: begin
          res_q.done <= 1'b0;
          bits_q     <= {bits_q[DATA_BITS-2:0], bit_val};
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == BITCNT_BITS'(DATA_BITS - 1)) begin
            state_q <= DEC_CHECK;
          end
        end
        DEC_CHECK: begin
          res_q.done <= 1'b1;
          if (b4 != sum8) begin
            res_q.status      <= ST_CHECKSUM;
            res_q.humidity    <= '0;
            res_q.temperature <= '0;
          end else begin
            res_q.status      <= ST_OK;
            res_q.humidity    <= {b0, b1};
            res_q.temperature <= b2[7] ? (16'd0 - mag) : mag;
          end
          state_q <= DEC_IDLE;
        end
        default: begin
          res_q.done <= 1'b0;
          state_q    <= DEC_IDLE;
        end
      endcase
    end
  end

  assign shift_o  = (state_q == DEC_SHIFT);
  assign result_o = res_q;

endmodule

FILE: tb/sv/dht22_single_wire_reader_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht22_single_wire_reader_unit_tb - self-checking bench for the sensor reader
// Feeds start and tick transfers, predicts every result with its own sequencer
// and frame decoder, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module dht22_single_wire_reader_unit_tb
  import dht_pkg::*;
;

  // The run ends here even if the block hangs.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Only the first mismatches are printed in full; all of them are counted.
  localparam int unsigned SHOWN_MISMATCHES = 30;
  // The stall pattern that keeps the output held off while items pile up.
  localparam int unsigned LONG_HOLD_AFTER = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_PREAMBLE,
    SQ_START_LOW,
    SQ_RELEASE,
    SQ_WAIT_RESP,
    SQ_LOW,
    SQ_HIGH
  } seq_phase_e;

  typedef struct packed {
    logic mode;
    logic pin;
  } wire_sample_t;

  typedef struct packed {
    logic               drive_en;
    logic               drive_lvl;
    logic               done;
    logic [1:0]         status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
  } wire_result_t;

  // --------------------------------------------------------------------------
  // Signals around the block. Everything the bench drives starts known.
  // --------------------------------------------------------------------------
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    mode_i = 1'b0;
  logic                    pin_level_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    drive_enable_o;
  logic                    drive_level_o;
  logic                    done_res_o;
  logic [1:0]              status_o;
  logic [15:0]             humidity_tenths_o;
  logic signed [15:0]      temperature_tenths_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = REG_PREAMBLE_HIGH;
  logic [COUNT_BITS-1:0]   cfg_wdata_i = '0;

  dht22_single_wire_reader_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mode_i              (mode_i),
    .pin_level_i         (pin_level_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .drive_enable_o      (drive_enable_o),
    .drive_level_o       (drive_level_o),
    .done_res_o          (done_res_o),
    .status_o            (status_o),
    .humidity_tenths_o   (humidity_tenths_o),
    .temperature_tenths_o(temperature_tenths_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench bookkeeping.
  // --------------------------------------------------------------------------
  wire_sample_t queued_samples[$];    // items not yet offered to the block
  wire_result_t pending_readings[$];  // results owed for accepted items

  logic [31:0] cycle_count = '0;
  int unsigned samples_queued = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned fault_count = 0;
  int unsigned settings_used = 0;
  int unsigned reads_by_status[4] = '{default: 0};

  // --------------------------------------------------------------------------
  // Predictor state: the timing registers as the block should hold them, and
  // the read sequencer. Registers are 24 bits and so never exceed COUNT_MAX,
  // so no clamping of the register values is needed here.
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] preamble_len = PREAMBLE_HIGH_RST;
  logic [COUNT_BITS-1:0] start_low_len = START_LOW_RST;
  logic [COUNT_BITS-1:0] release_len = RELEASE_HIGH_RST;
  logic [COUNT_BITS-1:0] timeout_len = TIMEOUT_RST;

  seq_phase_e            sq_phase = SQ_IDLE;
  logic [COUNT_BITS-1:0] sq_count = '0;
  int unsigned           pair_idx = 0;
  logic [31:0]           low_sum = '0;
  logic [COUNT_BITS-1:0] high_w[DATA_BITS];

  logic        fin_done;
  logic [1:0]  fin_status;
  logic [15:0] fin_hum;
  logic [15:0] fin_temp;

  function automatic logic is_driving();
    return sq_phase inside {SQ_PREAMBLE, SQ_START_LOW, SQ_RELEASE};
  endfunction

  function automatic logic [COUNT_BITS-1:0] drive_ticks(seq_phase_e p);
    case (p)
      SQ_PREAMBLE:  return preamble_len;
      SQ_START_LOW: return start_low_len;
      default:      return release_len;
    endcase
  endfunction

  // Drive steps programmed to zero ticks are passed over at once.
  function automatic void skip_empty_drive();
    while (is_driving() && drive_ticks(sq_phase) == '0)
      sq_phase = seq_phase_e'(sq_phase + 1);
  endfunction

  function automatic void end_read(logic [1:0] st);
    sq_phase = SQ_IDLE;
    sq_count = '0;
    fin_done = 1'b1;
    fin_status = st;
  endfunction

  // Counts one sample of the current wait; true when the wait ran out.
  function automatic logic count_sample(logic [1:0] st);
    if (sq_count != COUNT_MAX) sq_count++;
    if (sq_count >= timeout_len) begin
      end_read(st);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // The threshold is the floor of the mean data low width. Bits go MSB first.
  function automatic void decode_frame();
    logic [31:0] thr;
    logic [7:0]  b[5];
    logic [14:0] mag;
    thr = low_sum / DATA_BITS;
    foreach (b[i]) b[i] = '0;
    for (int k = 0; k < DATA_BITS; k++)
      b[k / 8] = {b[k / 8][6:0], ({8'd0, high_w[k]} >= thr)};
    if (b[4] != 8'(b[0] + b[1] + b[2] + b[3])) begin
      end_read(ST_CHECKSUM);
      return;
    end
    end_read(ST_OK);
    fin_hum = {b[0], b[1]};
    // Temperature comes as sign and magnitude; negative zero reads as zero.
    mag = {b[2][6:0], b[3]};
    fin_temp = b[2][7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
  endfunction

  // A level change closes the current pulse, and the same sample is the first
  // one counted in the next pulse. The sample that closes the last high pulse
  // triggers the decode instead.
  function automatic void pulse_sample(logic pin);
    if (sq_phase == SQ_LOW) begin
      if (!pin) begin
        void'(count_sample(ST_PULSE_TIMEOUT));
        return;
      end
      if (pair_idx > 0) low_sum += sq_count;
      sq_phase = SQ_HIGH;
      sq_count = '0;
    end
    if (sq_phase == SQ_HIGH) begin
      if (pin) begin
        void'(count_sample(ST_PULSE_TIMEOUT));
        return;
      end
      if (pair_idx > 0 && pair_idx <= DATA_BITS) high_w[pair_idx - 1] = sq_count;
      pair_idx++;
      if (pair_idx >= PULSE_PAIRS) begin
        decode_frame();
        return;
      end
      sq_phase = SQ_LOW;
      sq_count = '0;
      void'(count_sample(ST_PULSE_TIMEOUT));
    end
  endfunction

  // Advances the sequencer by one accepted item and returns what the block
  // must show for it.
  function automatic wire_result_t next_reading(logic mode, logic pin);
    wire_result_t r;
    logic         drv;
    fin_done = 1'b0;
    fin_status = ST_OK;
    fin_hum = '0;
    fin_temp = '0;
    if (mode) begin
      // A start also aborts any read in progress, without a result.
      sq_phase = SQ_PREAMBLE;
      sq_count = '0;
      pair_idx = 0;
      low_sum = '0;
      skip_empty_drive();
    end else if (is_driving()) begin
      if (sq_count != COUNT_MAX) sq_count++;
      if (sq_count >= drive_ticks(sq_phase)) begin
        sq_phase = seq_phase_e'(sq_phase + 1);
        sq_count = '0;
        skip_empty_drive();
      end
    end else if (sq_phase == SQ_WAIT_RESP) begin
      if (pin) begin
        void'(count_sample(ST_NO_RESPONSE));
      end else begin
        sq_phase = SQ_LOW;
        sq_count = '0;
        pair_idx = 0;
        low_sum = '0;
        pulse_sample(pin);
      end
    end else if (sq_phase == SQ_LOW || sq_phase == SQ_HIGH) begin
      pulse_sample(pin);
    end else begin
      sq_phase = SQ_IDLE;
    end
    drv = is_driving();
    r.drive_en = drv;
    r.drive_lvl = drv && sq_phase != SQ_START_LOW;
    r.done = fin_done;
    r.status = fin_status;
    r.humidity = fin_hum;
    r.temperature = fin_temp;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Items go out in bursts of random length separated by random
  // gaps; about one burst in four has no gap after it. An offered item holds
  // still until its transfer completes, and each accepted item is run through
  // the predictor right away.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    wire_sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= 1'b0;
      pin_level_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_readings.push_back(next_reading(mode_i, pin_level_i));
        samples_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          nxt = queued_samples.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= nxt.mode;
          pin_level_i <= nxt.pin;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall. The pattern rotates through four modes in turn: free running, light
  // random stalls, heavy random stalls, and a fixed duty cycle. Once, after a
  // number of results, the output is held off for a long stretch while the
  // driver keeps offering items, so the block has to stall its input.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && readings_seen >= LONG_HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      case (cycle_count[8:7])
        2'd0:    out_stall_i <= 1'b0;
        2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (cycle_count[2:0] < 3'd3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each result transfer is matched against the oldest owed
  // result.
  // --------------------------------------------------------------------------
  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= SHOWN_MISMATCHES)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    wire_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        fault_count++;
        $display("%0t ns: result transfer with no item waiting for it", $time);
      end else begin
        want = pending_readings.pop_front();
        compare_field("drive_enable", 32'(want.drive_en), 32'(drive_enable_o));
        compare_field("drive_level", 32'(want.drive_lvl), 32'(drive_level_o));
        compare_field("done_res", 32'(want.done), 32'(done_res_o));
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("humidity_tenths", 32'(want.humidity), 32'(humidity_tenths_o));
        compare_field("temperature_tenths", {16'd0, want.temperature},
                      {16'd0, temperature_tenths_o});
        if (want.done) reads_by_status[want.status]++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: gave up with %0d results still owed", $time,
               pending_readings.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building blocks.
  // --------------------------------------------------------------------------
  task automatic push_item(logic mode, logic pin);
    queued_samples.push_back('{mode: mode, pin: pin});
    samples_queued++;
  endtask

  task automatic push_run(logic pin, int unsigned n);
    repeat (n) push_item(1'b0, pin);
  endtask

  // Random items between reads: mostly ticks, now and then a stray start.
  task automatic push_noise();
    repeat ($urandom_range(1, 4))
      push_item($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
  endtask

  // One read as the sensor would answer it, with random content. Some reads
  // are spoiled on purpose: a bad checksum, a frame cut short (the next start
  // aborts it), one stretched low pulse, or a response that comes late.
  task automatic push_frame();
    int unsigned kind;
    int unsigned stop_at;
    int unsigned stretch_at;
    int unsigned thr;
    int unsigned sum;
    int unsigned lows[DATA_BITS];
    int unsigned highs[DATA_BITS];
    logic [7:0]  bytes[5];
    logic        bit_val;
    kind = $urandom_range(0, 9);
    push_item(1'b1, 1'($urandom_range(0, 1)));
    repeat (int'(preamble_len) + int'(start_low_len) + int'(release_len))
      push_item(1'b0, 1'($urandom_range(0, 1)));
    // The wire idles high until the sensor answers.
    if (kind == 9)
      push_run(1'b1, (timeout_len >= 24'd40) ? 6 : int'(timeout_len) + 1);
    else
      push_run(1'b1, $urandom_range(0, 3));
    // Response pulse pair, not decoded.
    push_run(1'b0, $urandom_range(2, 3));
    push_run(1'b1, $urandom_range(2, 3));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       bytes[i] = 8'h00;
        1:       bytes[i] = 8'hFF;
        default: bytes[i] = 8'($urandom_range(0, 255));
      endcase
    end
    bytes[4] = bytes[0] + bytes[1] + bytes[2] + bytes[3];
    if (kind == 6) bytes[4] ^= 8'(1 << $urandom_range(0, 7));
    sum = 0;
    foreach (lows[k]) begin
      lows[k] = $urandom_range(2, 3);
      sum += lows[k];
    end
    thr = sum / DATA_BITS;
    foreach (highs[k]) begin
      bit_val = bytes[k / 8][7 - (k % 8)];
      highs[k] = bit_val ? $urandom_range(thr, thr + 1) : $urandom_range(1, thr - 1);
    end
    if (kind == 8) begin
      stretch_at = $urandom_range(0, DATA_BITS - 1);
      lows[stretch_at] = 12;
    end
    stop_at = (kind == 7) ? $urandom_range(0, DATA_BITS - 1) : DATA_BITS;
    for (int k = 0; k < stop_at; k++) begin
      push_run(1'b0, lows[k]);
      push_run(1'b1, highs[k]);
    end
    // The falling edge after the last high pulse closes the frame.
    if (kind != 7) push_item(1'b0, 1'b0);
  endtask

  // Holds the driver back until every item went out and every result came.
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (queued_samples.size() != 0 || in_valid_i || pending_readings.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COUNT_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PREAMBLE_HIGH: preamble_len = val;
      REG_START_LOW:     start_low_len = val;
      REG_RELEASE_HIGH:  release_len = val;
      default:           timeout_len = val;
    endcase
  endtask

  // Every phase that writes the registers begins with a start item, so any
  // read left hanging by the previous phase is thrown away first.
  task automatic set_timing(logic [COUNT_BITS-1:0] pre, logic [COUNT_BITS-1:0] low,
                            logic [COUNT_BITS-1:0] rel, logic [COUNT_BITS-1:0] tmo);
    write_reg(REG_PREAMBLE_HIGH, pre);
    write_reg(REG_START_LOW, low);
    write_reg(REG_RELEASE_HIGH, rel);
    write_reg(REG_TIMEOUT, tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase(logic [COUNT_BITS-1:0] pre, logic [COUNT_BITS-1:0] low,
                                  logic [COUNT_BITS-1:0] rel, logic [COUNT_BITS-1:0] tmo,
                                  int unsigned budget);
    int unsigned stop_count;
    set_timing(pre, low, rel, tmo);
    stop_count = samples_queued + budget;
    do begin
      push_frame();
      if ($urandom_range(0, 3) == 0) push_noise();
    end while (samples_queued < stop_count);
    wait_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    foreach (high_w[k]) high_w[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // Reset timing: a tick while idle is ignored, then a start enters the
    // long preamble and stays there.
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    wait_until_drained();

    // All drive steps empty, zero timeout: the start goes straight to waiting
    // for the sensor, and the first counted sample of any wait runs out.
    set_timing('0, '0, '0, '0);
    push_item(1'b1, 1'b1);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b0);
    wait_until_drained();

    // Short drive steps: watch each level, then a low pulse that runs out,
    // then a start that aborts a read during its preamble.
    set_timing(24'd2, 24'd1, 24'd3, 24'd3);
    push_item(1'b1, 1'b1);
    repeat (6) push_item(1'b0, 1'($urandom_range(0, 1)));
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b1);
    wait_until_drained();

    // Every register at its top value.
    set_timing(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    wait_until_drained();

    // Full reads with random content under a range of timings, from a timeout
    // that never fires down to one that cuts most frames short.
    run_random_phase(24'd1, 24'd2, 24'd1, COUNT_MAX, 160);
    run_random_phase(COUNT_BITS'($urandom_range(0, 3)), COUNT_BITS'($urandom_range(0, 3)),
                     COUNT_BITS'($urandom_range(0, 3)), TIMEOUT_RST, 150);
    run_random_phase(COUNT_BITS'($urandom_range(0, 4)), COUNT_BITS'($urandom_range(0, 4)),
                     COUNT_BITS'($urandom_range(0, 4)), COUNT_BITS'($urandom_range(4, 8)),
                     150);
    run_random_phase(COUNT_BITS'($urandom_range(0, 2)), COUNT_BITS'($urandom_range(0, 2)),
                     COUNT_BITS'($urandom_range(0, 2)), COUNT_BITS'($urandom_range(2, 3)),
                     140);

    repeat (50) @(posedge clk_i);
    $display("Sent %0d item transfers under %0d timing settings, %0d results checked.",
             samples_sent, settings_used, readings_seen);
    $display("Reads ended: %0d ok, %0d no response, %0d pulse timeout, %0d bad checksum.",
             reads_by_status[ST_OK], reads_by_status[ST_NO_RESPONSE],
             reads_by_status[ST_PULSE_TIMEOUT], reads_by_status[ST_CHECKSUM]);
    if (fault_count == 0 && pending_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fault_count,
               pending_readings.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
